// ----- hdl/ppqd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppqd_pkg
// Shared constants, control state and cell control bundle for the
// polynomial product/quotient derivative block.
// ----------------------------------------------------------------------------
package ppqd_pkg;

    localparam int MAX_DEGREE_DEF = 10;
    localparam int COEF_WIDTH_DEF = 16;

    // width of one result coefficient, sums wrap at this width
    localparam int RES_W = 41;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_MUL,
        ST_DRAIN,
        ST_OUT
    } ppqd_state_t;

    typedef struct packed {
        logic wr;         // store the incoming item in the matching cell
        logic prep;       // form masked coefficients and derivatives
        logic shift;      // advance p chain down and q chain up
        logic acc_clr;    // clear accumulators
        logic acc_en;     // add registered products
        logic out_shift;  // move accumulators toward cell 0
        logic sub;        // quotient numerator: subtract p*q'
    } ppqd_ctrl_t;

endpackage

// ----- hdl/poly_product_quotient_derivative.sv -----
// ----------------------------------------------------------------------------
// poly_product_quotient_derivative
// Derivative of p*q (p'q+pq') or quotient numerator (p'q-pq') over a row
// of coefficient cells; results leave one coefficient per cycle while m_ready is high.
// ----------------------------------------------------------------------------
// Loading takes one item per cycle. After the last item come a prep state,
// MAX_DEGREE+1 multiply steps through the cell chain and a drain state; the
// 11 results then follow at one per cycle while m_ready is high.
// Reset (aresetn, synchronous, active low) clears the controller, degrees
// and rule_mode; coefficient stores hold nothing valid until written.
module poly_product_quotient_derivative
    import ppqd_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    localparam int IW  = $clog2(MAX_DEGREE + 1),
    localparam int RDW = $clog2(2 * MAX_DEGREE) + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic                         cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic        [IW-1:0]         s_coef_index,
    input  logic signed [COEF_WIDTH-1:0] s_p_coef,
    input  logic signed [COEF_WIDTH-1:0] s_q_coef,
    input  logic        [IW-1:0]         s_p_degree,
    input  logic        [IW-1:0]         s_q_degree,
    input  logic                         s_last_coef,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [IW-1:0]         m_result_index,
    output logic signed [RES_W-1:0]      m_result_coef,
    output logic signed [RDW-1:0]        m_result_degree,
    output logic                         m_last_term
);

    localparam int N  = MAX_DEGREE + 1;
    localparam int MW = $clog2(MAX_DEGREE + 2);
    localparam int DW = COEF_WIDTH + MW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_DEGREE);

    ppqd_state_t state_reg, state_next;
    logic [IW-1:0] step_reg, step_next;
    logic [IW-1:0] p_deg_reg, q_deg_reg;
    logic          rule_mode_reg;
    logic          prod_vld_reg;
    ppqd_ctrl_t    ctrl;
    logic          in_fire, out_fire;

    logic signed [COEF_WIDTH-1:0] p_o  [N];
    logic signed [COEF_WIDTH-1:0] q_o  [N];
    logic signed [DW-1:0]         pa_o [N];
    logic signed [COEF_WIDTH-1:0] pm_o [N];
    logic signed [DW-1:0]         qd_o [N];
    logic signed [COEF_WIDTH-1:0] qm_o [N];
    logic signed [RES_W-1:0]      acc_o[N];

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    // next state and step counter
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire && s_last_coef) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_MUL;
                step_next  = '0;
            end
            ST_MUL: begin
                if (step_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
                step_next  = '0;
            end
            ST_OUT: begin
                if (out_fire) begin
                    if (step_reg == LAST_IDX) begin
                        state_next = ST_LOAD;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs and cell controls
    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        ctrl           = '0;
        ctrl.sub       = rule_mode_reg;
        ctrl.acc_en    = prod_vld_reg;
        case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                ctrl.wr  = s_valid;
            end
            ST_PREP: begin
                ctrl.prep    = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            ST_MUL: begin
                ctrl.shift = 1'b1;
            end
            ST_DRAIN: begin
                ctrl.shift = 1'b0;
            end
            ST_OUT: begin
                m_valid        = 1'b1;
                ctrl.out_shift = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            step_reg      <= '0;
            p_deg_reg     <= '0;
            q_deg_reg     <= '0;
            rule_mode_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            prod_vld_reg <= (state_reg == ST_MUL);
            if (cfg_we) begin
                rule_mode_reg <= cfg_wdata;
            end
            if (in_fire && s_last_coef) begin
                // degrees above the top power saturate
                p_deg_reg <= (s_p_degree > LAST_IDX) ? LAST_IDX : s_p_degree;
                q_deg_reg <= (s_q_degree > LAST_IDX) ? LAST_IDX : s_q_degree;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic signed [COEF_WIDTH-1:0] p_up, q_up, pm_up, qm_dn;
        logic signed [DW-1:0]         pa_up, qd_dn;
        logic signed [RES_W-1:0]      acc_up;

        if (k == N - 1) begin : g_top
            assign p_up   = '0;
            assign q_up   = '0;
            assign pa_up  = '0;
            assign pm_up  = '0;
            assign acc_up = '0;
        end else begin : g_mid
            assign p_up   = p_o[k+1];
            assign q_up   = q_o[k+1];
            assign pa_up  = pa_o[k+1];
            assign pm_up  = pm_o[k+1];
            assign acc_up = acc_o[k+1];
        end

        if (k == 0) begin : g_bot
            assign qd_dn = '0;
            assign qm_dn = '0;
        end else begin : g_low
            assign qd_dn = qd_o[k-1];
            assign qm_dn = qm_o[k-1];
        end

        ppqd_cell #(
            .MAX_DEGREE (MAX_DEGREE),
            .COEF_WIDTH (COEF_WIDTH),
            .CELL_IDX   (k)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .wr_idx  (s_coef_index),
            .wr_p    (s_p_coef),
            .wr_q    (s_q_coef),
            .p_deg   (p_deg_reg),
            .q_deg   (q_deg_reg),
            .p_up    (p_up),
            .q_up    (q_up),
            .pa_up   (pa_up),
            .pm_up   (pm_up),
            .qd_dn   (qd_dn),
            .qm_dn   (qm_dn),
            .head_pa (pa_o[0]),
            .head_pm (pm_o[0]),
            .acc_up  (acc_up),
            .p_out   (p_o[k]),
            .q_out   (q_o[k]),
            .pa_out  (pa_o[k]),
            .pm_out  (pm_o[k]),
            .qd_out  (qd_o[k]),
            .qm_out  (qm_o[k]),
            .acc_out (acc_o[k])
        );
    end

    assign m_result_index  = step_reg;
    assign m_result_coef   = acc_o[0];
    assign m_result_degree = RDW'(p_deg_reg) + RDW'(q_deg_reg) - RDW'(1);
    assign m_last_term     = (step_reg == LAST_IDX);

endmodule

// ----- hdl/ppqd_cell.sv -----
// ----------------------------------------------------------------------------
// ppqd_cell
// One coefficient slot: holds p and q at its power, the shifting chains of
// masked coefficients and derivatives, a product stage and an accumulator.
// ----------------------------------------------------------------------------
module ppqd_cell
    import ppqd_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IW = $clog2(MAX_DEGREE + 1),
    localparam int MW = $clog2(MAX_DEGREE + 2),
    localparam int DW = COEF_WIDTH + MW
) (
    input  logic                         aclk,
    input  ppqd_ctrl_t                   ctrl,
    input  logic        [IW-1:0]         wr_idx,
    input  logic signed [COEF_WIDTH-1:0] wr_p,
    input  logic signed [COEF_WIDTH-1:0] wr_q,
    input  logic        [IW-1:0]         p_deg,
    input  logic        [IW-1:0]         q_deg,
    input  logic signed [COEF_WIDTH-1:0] p_up,
    input  logic signed [COEF_WIDTH-1:0] q_up,
    input  logic signed [DW-1:0]         pa_up,
    input  logic signed [COEF_WIDTH-1:0] pm_up,
    input  logic signed [DW-1:0]         qd_dn,
    input  logic signed [COEF_WIDTH-1:0] qm_dn,
    input  logic signed [DW-1:0]         head_pa,
    input  logic signed [COEF_WIDTH-1:0] head_pm,
    input  logic signed [RES_W-1:0]      acc_up,
    output logic signed [COEF_WIDTH-1:0] p_out,
    output logic signed [COEF_WIDTH-1:0] q_out,
    output logic signed [DW-1:0]         pa_out,
    output logic signed [COEF_WIDTH-1:0] pm_out,
    output logic signed [DW-1:0]         qd_out,
    output logic signed [COEF_WIDTH-1:0] qm_out,
    output logic signed [RES_W-1:0]      acc_out
);

    localparam logic        [IW-1:0] K   = IW'(CELL_IDX);
    localparam logic signed [MW:0]   KP1 = (MW + 1)'(CELL_IDX + 1);

    logic signed [COEF_WIDTH-1:0]          p_reg, q_reg;
    logic signed [DW-1:0]                  pa_reg, qd_reg;
    logic signed [COEF_WIDTH-1:0]          pm_reg, qm_reg;
    logic signed [RES_W-1:0]               prod_a_reg, prod_b_reg, acc_reg;
    logic signed [COEF_WIDTH+MW:0]         dp_full, dq_full;
    logic signed [DW+COEF_WIDTH-1:0]       prod_a, prod_b;
    logic signed [RES_W-1:0]               acc_next;

    // derivative term k: (k+1) * c[k+1]
    assign dp_full = p_up * KP1;
    assign dq_full = q_up * KP1;

    assign prod_a = head_pa * qm_reg;   // p' * q
    assign prod_b = head_pm * qd_reg;   // p * q'

    always_comb begin
        if (ctrl.sub) begin
            acc_next = acc_reg + prod_a_reg - prod_b_reg;
        end else begin
            acc_next = acc_reg + prod_a_reg + prod_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr && wr_idx == K) begin
            p_reg <= wr_p;
            q_reg <= wr_q;
        end

        if (ctrl.prep) begin
            pa_reg <= (K < p_deg) ? DW'(dp_full) : '0;
            pm_reg <= (K <= p_deg) ? p_reg : '0;
            qd_reg <= (K < q_deg) ? DW'(dq_full) : '0;
            qm_reg <= (K <= q_deg) ? q_reg : '0;
        end else if (ctrl.shift) begin
            pa_reg <= pa_up;
            pm_reg <= pm_up;
            qd_reg <= qd_dn;
            qm_reg <= qm_dn;
        end

        prod_a_reg <= RES_W'(prod_a);
        prod_b_reg <= RES_W'(prod_b);

        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end else if (ctrl.out_shift) begin
            acc_reg <= acc_up;
        end
    end

    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign pa_out  = pa_reg;
    assign pm_out  = pm_reg;
    assign qd_out  = qd_reg;
    assign qm_out  = qm_reg;
    assign acc_out = acc_reg;

endmodule
